### src/url_target_query_parser_core_defines.svh
// Assertion macros shared by the URL target query parser RTL.
`ifndef URL_TARGET_QUERY_PARSER_CORE_DEFINES_SVH
`define URL_TARGET_QUERY_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define UTQP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define UTQP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define UTQP_ASSERT(label, cond, msg)
`define UTQP_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### src/utqp_pkg.sv
// Package with the item types, character codes and decode helpers of the parser.
package utqp_pkg;

  // Input item: one raw byte of the request target.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  // Result item: a decoded byte or a marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] token_kind;
    logic       token_end;
    logic       target_end;
  } out_item_t;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  // All results caused by one input item, in order.
  typedef struct packed {
    out_item_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]        cnt;
  } bundle_t;

  // Queue between the classifier and the output serializer (power of two).
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

  localparam logic [1:0] KIND_PATH  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  localparam logic [1:0] REG_PATH  = 2'd0;
  localparam logic [1:0] REG_KEY   = 2'd1;
  localparam logic [1:0] REG_VALUE = 2'd2;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_D0 && c <= CH_D9) begin
      t = c - CH_D0;
      return {1'b1, t[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + HEX_ALPHA_OFS;
      return {1'b1, t[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + HEX_ALPHA_OFS;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // Unreachable region code 3 counts as the value region.
  function automatic logic [1:0] kind_of(logic [1:0] region);
    case (region)
      REG_PATH: return KIND_PATH;
      REG_KEY:  return KIND_KEY;
      default:  return KIND_VALUE;
    endcase
  endfunction

  function automatic out_item_t mk_res(logic [7:0] b, logic has, logic [1:0] kind,
                                       logic tend);
    out_item_t r;
    r.out_byte   = b;
    r.has_byte   = has;
    r.token_kind = kind;
    r.token_end  = tend;
    r.target_end = 1'b0;
    return r;
  endfunction

  // Appends a result unless the bundle is already full.
  function automatic bundle_t push(bundle_t b, out_item_t r);
    bundle_t o;
    o = b;
    if (b.cnt < CNT_W'(MAX_RES)) begin
      o.res[b.cnt[IDX_W-1:0]] = r;
      o.cnt = b.cnt + CNT_W'(1);
    end
    return o;
  endfunction

  // Emits a half-seen percent sequence literally.
  function automatic bundle_t flush_pend(bundle_t b, logic [1:0] pc, logic [7:0] hc,
                                         logic [1:0] kind);
    bundle_t o;
    o = b;
    if (pc == PEND_ONE || pc == PEND_TWO) begin
      o = push(o, mk_res(CH_PCT, 1'b1, kind, 1'b0));
      if (pc == PEND_TWO) begin
        o = push(o, mk_res(hc, 1'b1, kind, 1'b0));
      end
    end
    return o;
  endfunction

endpackage

### src/utqp_front.sv
// Front end: accepts raw bytes, tracks the token state and builds each item's results.
module utqp_front
  import utqp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     push_o,
  output bundle_t  push_data_o
);

  logic [1:0] region_q, region_d;
  logic [1:0] pend_q, pend_d;
  logic [7:0] hex_q, hex_d;
  logic       ks_q, ks_d;

  logic       accept;
  logic [7:0] c;
  logic       delim;
  logic       do_fresh;
  logic [4:0] lo, hi;
  logic [1:0] kind_end;
  bundle_t    b;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = in_item_i.in_byte;
  assign lo         = hex_val(c);
  assign hi         = hex_val(hex_q);

  always_comb begin
    region_d = region_q;
    pend_d   = pend_q;
    hex_d    = hex_q;
    ks_d     = ks_q;
    b        = '0;
    do_fresh = 1'b0;
    kind_end = KIND_PATH;

    case (region_q)
      REG_PATH: delim = (c == CH_QM);
      REG_KEY:  delim = (c == CH_AMP) || (c == CH_EQ);
      default:  delim = (c == CH_AMP);
    endcase

    if (delim) begin
      b      = flush_pend(b, pend_q, hex_q, kind_of(region_q));
      pend_d = PEND_NONE;
      hex_d  = 8'd0;
      case (region_q)
        REG_PATH: begin
          b        = push(b, mk_res(8'd0, 1'b0, KIND_PATH, 1'b1));
          region_d = REG_KEY;
          ks_d     = 1'b0;
        end
        REG_KEY: begin
          if (c == CH_EQ) begin
            b        = push(b, mk_res(8'd0, 1'b0, KIND_KEY, 1'b1));
            region_d = REG_VALUE;
          end else begin
            if (ks_q) begin
              b = push(b, mk_res(8'd0, 1'b0, KIND_VALUE, 1'b1));
            end
            ks_d = 1'b0;
          end
        end
        default: begin
          b        = push(b, mk_res(8'd0, 1'b0, KIND_VALUE, 1'b1));
          region_d = REG_KEY;
          ks_d     = 1'b0;
        end
      endcase
    end else begin
      if (region_q == REG_KEY) begin
        ks_d = 1'b1;
      end
      if (pend_q == PEND_TWO) begin
        if (lo[4] && hi[4]) begin
          b = push(b, mk_res({hi[3:0], lo[3:0]}, 1'b1, kind_of(region_q), 1'b0));
        end else begin
          b        = flush_pend(b, pend_q, hex_q, kind_of(region_q));
          do_fresh = 1'b1;
        end
        pend_d = PEND_NONE;
        hex_d  = 8'd0;
      end else if (pend_q == PEND_ONE) begin
        if (lo[4]) begin
          pend_d = PEND_TWO;
          hex_d  = c;
        end else begin
          b        = flush_pend(b, pend_q, hex_q, kind_of(region_q));
          pend_d   = PEND_NONE;
          hex_d    = 8'd0;
          do_fresh = 1'b1;
        end
      end else begin
        pend_d   = PEND_NONE;
        do_fresh = 1'b1;
      end
      if (do_fresh) begin
        if (c == CH_PCT) begin
          pend_d = PEND_ONE;
        end else begin
          b = push(b, mk_res((c == CH_PLUS) ? CH_SPACE : c, 1'b1, kind_of(region_q), 1'b0));
        end
      end
    end

    if (in_item_i.is_last) begin
      kind_end = kind_of(region_d);
      b = flush_pend(b, pend_d, hex_d, kind_end);
      case (region_d)
        REG_PATH: b = push(b, mk_res(8'd0, 1'b0, KIND_PATH, 1'b1));
        REG_KEY: begin
          if (ks_d) begin
            b = push(b, mk_res(8'd0, 1'b0, KIND_VALUE, 1'b1));
          end
        end
        default:  b = push(b, mk_res(8'd0, 1'b0, KIND_VALUE, 1'b1));
      endcase
      if (b.cnt == '0) begin
        b = push(b, mk_res(8'd0, 1'b0, kind_end, 1'b0));
      end
      b.res[b.cnt[IDX_W-1:0] - IDX_W'(1)].target_end = 1'b1;
      region_d = REG_PATH;
      pend_d   = PEND_NONE;
      hex_d    = 8'd0;
      ks_d     = 1'b0;
    end
  end

  assign push_o      = accept && (b.cnt != '0);
  assign push_data_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= REG_PATH;
      pend_q   <= PEND_NONE;
      hex_q    <= 8'd0;
      ks_q     <= 1'b0;
    end else if (accept) begin
      region_q <= region_d;
      pend_q   <= pend_d;
      hex_q    <= hex_d;
      ks_q     <= ks_d;
    end
  end

endmodule

### src/utqp_queue.sv
// Small FIFO of result bundles between the front end and the output serializer.
`include "url_target_query_parser_core_defines.svh"

module utqp_queue
  import utqp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    full_o,
  output logic    empty_o
);

  bundle_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q, count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  `UTQP_ASSERT(a_count_range, count_q <= (QPTR_W+1)'(QDEPTH), "queue count beyond depth")
  `UTQP_ASSERT(a_no_push_full, !(push_i && full_o), "push into a full queue")
  `UTQP_ASSERT(a_no_pop_empty, !(pop_i && empty_o), "pop from an empty queue")

endmodule

### src/utqp_back.sv
// Output serializer: hands out the results of each queued bundle one item per cycle unless stalled.
`include "url_target_query_parser_core_defines.svh"

module utqp_back
  import utqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   q_head_i,
  input  logic      q_empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] idx_ext;
  logic             out_valid_q;
  out_item_t        out_item_q;
  logic             slot_free;
  logic             load;
  logic             last_res;

  assign idx_ext   = CNT_W'(idx_q);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load      = slot_free && !q_empty_i;
  assign last_res  = (idx_ext == q_head_i.cnt - CNT_W'(1));
  assign pop_o     = load && last_res;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= q_head_i.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (slot_free) begin
        out_valid_q <= !q_empty_i;
      end
      if (load) begin
        idx_q <= last_res ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `UTQP_ASSERT(a_bundle_nonempty, q_empty_i || (q_head_i.cnt != '0), "empty bundle queued")
  `UTQP_ASSERT(a_idx_in_range, q_empty_i || (idx_ext < q_head_i.cnt), "index past bundle")
  `UTQP_ASSERT_NEXT(a_idx_restart, pop_o, idx_q == '0, "index not restarted after pop")

endmodule

### src/url_target_query_parser_core.sv
// An accepted item's results are written into the bundle queue and then loaded into the
// result register. Throughput: one input item per cycle while items yield at most one
// result each and the output is not stalled; an item with several results holds the
// single result register in turn; a four-bundle queue before it absorbs such bursts.
// Reset: asynchronous and active low; it returns the parser to the path region with nothing
// pending and empties the queue and the output register.
module url_target_query_parser_core
  import utqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // The front end classifies each byte against the current region and pending percent
  // sequence, and packs every result that byte causes into one bundle. Bytes that cause
  // no result leave only a state update behind and are not queued.
  logic    push;
  bundle_t push_data;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  bundle_t q_head;

  utqp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue decouples the two sides, so the input keeps flowing while the output
  // is stalled, until all four bundle slots are taken.
  utqp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // The back end walks through the head bundle and drives one registered result per cycle
  // unless the output stalls; it releases the bundle when its last result is loaded.
  utqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_head_i    (q_head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### dv/url_target_query_parser_core_tb.sv
// Self-checking testbench for the streaming URL target splitter and percent-decoder.
module url_target_query_parser_core_tb
  import utqp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam string PASS_MSG = "url_target_query_parser_core verification clean";

  // Clock, reset and the two item channels. Every input has a known value from time zero.
  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  url_target_query_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Idle rates of the two sides, in percent of cycles, and the receiver hold-off request.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int          hold_req    = 0;
  int          hold_left   = 0;
  int          items_sent  = 0;
  int          n_errors    = 0;

  // Decoded results still owed by the block, oldest first.
  out_item_t decoded_q[$];
  // Bytes of the request target that is about to be sent.
  logic [7:0] tgt_q[$];

  // Shadow state of the parser: region, the half-seen percent sequence and
  // whether the current query pair has any byte yet.
  logic [1:0] p_region   = REG_PATH;
  logic [1:0] p_pend     = PEND_NONE;
  logic [7:0] p_hex      = 8'h00;
  logic       p_key_seen = 1'b0;
  // Results caused by the byte being decoded; the block never makes more than four.
  out_item_t  step_res[MAX_RES];
  int         n_step;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on run time, well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("url_target_query_parser_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Value of a hex digit in either case, or -1 when the byte is no hex digit.
  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CH_D0 && c <= CH_D9) return int'(c) - int'(CH_D0);
    if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic [1:0] region_kind();
    case (p_region)
      REG_PATH: return KIND_PATH;
      REG_KEY:  return KIND_KEY;
      default:  return KIND_VALUE;
    endcase
  endfunction

  function automatic void emit(logic [7:0] b, logic has, logic [1:0] kind, logic tend);
    if (n_step < MAX_RES) begin
      step_res[n_step].out_byte   = b;
      step_res[n_step].has_byte   = has;
      step_res[n_step].token_kind = kind;
      step_res[n_step].token_end  = tend;
      step_res[n_step].target_end = 1'b0;
      n_step++;
    end
  endfunction

  // A percent sign and possibly one held digit go out as plain bytes.
  function automatic void flush_partial();
    if (p_pend == PEND_ONE || p_pend == PEND_TWO) begin
      emit(CH_PCT, 1'b1, region_kind(), 1'b0);
      if (p_pend == PEND_TWO) emit(p_hex, 1'b1, region_kind(), 1'b0);
    end
    p_pend = PEND_NONE;
    p_hex  = 8'h00;
  endfunction

  // A data byte with nothing pending: a percent sign opens a sequence, a plus is a space.
  function automatic void take_fresh(logic [7:0] c);
    if (c == CH_PCT) begin
      p_pend = PEND_ONE;
    end else begin
      emit((c == CH_PLUS) ? CH_SPACE : c, 1'b1, region_kind(), 1'b0);
    end
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void decode_target_byte(in_item_t it);
    logic [7:0] c;
    logic       is_delim;
    logic [1:0] kind_here;
    int         hi;
    int         lo;
    c      = it.in_byte;
    n_step = 0;
    case (p_region)
      REG_PATH: is_delim = (c == CH_QM);
      REG_KEY:  is_delim = (c == CH_AMP) || (c == CH_EQ);
      default:  is_delim = (c == CH_AMP);
    endcase

    if (is_delim) begin
      flush_partial();
      if (p_region == REG_PATH) begin
        emit(8'h00, 1'b0, KIND_PATH, 1'b1);
        p_region   = REG_KEY;
        p_key_seen = 1'b0;
      end else if (p_region == REG_KEY) begin
        if (c == CH_EQ) begin
          emit(8'h00, 1'b0, KIND_KEY, 1'b1);
          p_region = REG_VALUE;
        end else begin
          // An ampersand closes a key without value; an empty pair says nothing.
          if (p_key_seen) emit(8'h00, 1'b0, KIND_VALUE, 1'b1);
          p_key_seen = 1'b0;
        end
      end else begin
        emit(8'h00, 1'b0, KIND_VALUE, 1'b1);
        p_region   = REG_KEY;
        p_key_seen = 1'b0;
      end
    end else begin
      if (p_region == REG_KEY) p_key_seen = 1'b1;
      if (p_pend == PEND_TWO) begin
        hi = hex_nibble(p_hex);
        lo = hex_nibble(c);
        if (hi >= 0 && lo >= 0) begin
          emit(8'(hi * 16 + lo), 1'b1, region_kind(), 1'b0);
          p_pend = PEND_NONE;
          p_hex  = 8'h00;
        end else begin
          flush_partial();
          take_fresh(c);
        end
      end else if (p_pend == PEND_ONE) begin
        if (hex_nibble(c) >= 0) begin
          p_pend = PEND_TWO;
          p_hex  = c;
        end else begin
          flush_partial();
          take_fresh(c);
        end
      end else begin
        p_pend = PEND_NONE;
        take_fresh(c);
      end
    end

    if (it.is_last) begin
      kind_here = region_kind();
      flush_partial();
      if (p_region == REG_PATH) begin
        emit(8'h00, 1'b0, KIND_PATH, 1'b1);
      end else if (p_region == REG_KEY) begin
        if (p_key_seen) emit(8'h00, 1'b0, KIND_VALUE, 1'b1);
      end else begin
        emit(8'h00, 1'b0, KIND_VALUE, 1'b1);
      end
      // A final byte that reports nothing still yields one bare closing result.
      if (n_step == 0) emit(8'h00, 1'b0, kind_here, 1'b0);
      step_res[n_step - 1].target_end = 1'b1;
      p_region   = REG_PATH;
      p_pend     = PEND_NONE;
      p_hex      = 8'h00;
      p_key_seen = 1'b0;
    end

    for (int i = 0; i < n_step; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      n_errors++;
    end
  endfunction

  // Every accepted result is matched against the oldest decoded result still owed.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item_o);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        compare_field("out_byte",   want.out_byte,   out_item_o.out_byte);
        compare_field("has_byte",   want.has_byte,   out_item_o.has_byte);
        compare_field("token_kind", want.token_kind, out_item_o.token_kind);
        compare_field("token_end",  want.token_end,  out_item_o.token_end);
        compare_field("target_end", want.target_end, out_item_o.target_end);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted down here when requested.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Appends one byte to the target being built.
  function automatic void add_byte(logic [7:0] b);
    tgt_q.insert(tgt_q.size(), b);
  endfunction

  // Offers one item from a falling edge on and returns at the falling edge after it
  // was taken. Valid stays high into the next item unless the sender idles first.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_target_byte(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Sends the bytes held in tgt_q as one target, marking the final byte.
  task automatic send_target();
    in_item_t it;
    for (int i = 0; i < tgt_q.size(); i++) begin
      it.in_byte = tgt_q[i];
      it.is_last = (i == tgt_q.size() - 1);
      send_item(it);
    end
  endtask

  task automatic send_text(string s);
    tgt_q.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_target();
  endtask

  // Stops offering items until every owed result has come out, then lets the pipeline settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random target generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h61, 8'h7A));
      1:       return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom_range(8'h41, 8'h5A));
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(CH_D0, CH_D9));
      1:       return 8'($urandom_range(CH_LA, CH_LF));
      default: return 8'($urandom_range(CH_UA, CH_UF));
    endcase
  endfunction

  // One unit of token content: a plain byte, a percent sequence that is good,
  // broken or cut short, a plus, a stray delimiter or any byte at all.
  function automatic void add_unit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      add_byte(plain_char());
    end else if (pick < 58) begin
      add_byte(CH_PCT);
      add_byte(hex_char());
      add_byte(hex_char());
    end else if (pick < 66) begin
      add_byte(CH_PCT);
      add_byte(hex_char());
      add_byte(plain_char());
    end else if (pick < 72) begin
      add_byte(CH_PCT);
    end else if (pick < 79) begin
      add_byte(CH_PLUS);
    end else if (pick < 84) begin
      add_byte($urandom_range(0, 1) ? CH_QM : CH_EQ);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Mostly well-formed targets (path, query, pairs) with random content; one in
  // ten is plain noise.
  function automatic void build_random_target();
    int n_pairs;
    tgt_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 5)) add_unit();
    if ($urandom_range(0, 9) != 0) begin
      add_byte(CH_QM);
      n_pairs = $urandom_range(0, 4);
      for (int k = 0; k < n_pairs; k++) begin
        if (k > 0) add_byte(CH_AMP);
        if ($urandom_range(0, 7) == 0) add_byte(CH_AMP);
        repeat ($urandom_range(0, 4)) add_unit();
        if ($urandom_range(0, 4) != 0) begin
          add_byte(CH_EQ);
          repeat ($urandom_range(0, 4)) add_unit();
        end
      end
      if ($urandom_range(0, 5) == 0) add_byte(CH_AMP);
    end
    if (tgt_q.size() == 0) add_byte(plain_char());
  endfunction

  task automatic send_random_targets(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      build_random_target();
      send_target();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked targets: empty path and empty key, raw '?' and '=' inside a value,
  // an unfinished sequence at the end with a bad third character, hex in both
  // cases, an encoded plus, a bad second character, a percent cut short by another
  // percent and then by the '?', an empty pair, a key with no '=', the lowest and
  // highest byte values, and a final byte that reports nothing.
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_text("?=?=%4g");
    send_text("%4A+%2b%g%%5?a&&b");
    tgt_q = '{8'h00, CH_QM, CH_AMP};
    send_target();
    tgt_q = '{8'hFF};
    send_target();
    drain_results();
  endtask

  task automatic test_random_phase(int unsigned tx_pct, int unsigned rx_pct, int n_items);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_random_targets(n_items);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items, so the bundle queue fills and the block stalls its input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 80;
    send_random_targets(45);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_phase(34, 75, 130);
    test_random_phase(75, 34, 130);
    test_backpressure();
    test_random_phase(0, 0, 130);

    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display(PASS_MSG);
    end else begin
      $display("url_target_query_parser_core verification failed");
    end
    $finish;
  end

endmodule
